/* src/midi_byte_stream_parser_core_defines.svh */
// Assertion macros shared by the MIDI byte stream parser RTL.
`ifndef MIDI_BYTE_STREAM_PARSER_CORE_DEFINES_SVH
`define MIDI_BYTE_STREAM_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MBP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define MBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/mbp_pkg.sv */
// Package with types, codes and helper functions of the MIDI byte stream parser.
package mbp_pkg;

   // Fixed field widths
   localparam int BYTE_W      = 8;
   localparam int TIME_W      = 32;
   localparam int CHAN_W      = 5;
   localparam int LEN_W       = 11;
   localparam int SIDX_W      = 10;
   localparam int SENSE_W     = 10;
   localparam int STATE_W     = 2;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 10;

   // Default SysEx buffer depth
   localparam int SYSEX_DEPTH_DEF = 128;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LISTEN_CHANNEL = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NULL_VEL_OFF   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSE_ENABLE   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSE_TIMEOUT  = 4'd3;

   // Configuration reset values
   localparam logic [CHAN_W-1:0]  LISTEN_RESET    = 5'd0;
   localparam logic [SENSE_W-1:0] TIMEOUT_RESET   = 10'd300;
   localparam logic [CHAN_W-1:0]  LISTEN_DISABLED = 5'd17;
   localparam logic [CHAN_W-1:0]  LISTEN_OMNI     = 5'd0;
   localparam logic [SENSE_W-1:0] SENSE_MAX       = 10'd1023;

   // Item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Status codes
   localparam logic [BYTE_W-1:0] ST_NONE      = 8'h00;
   localparam logic [BYTE_W-1:0] ST_NOTE_OFF  = 8'h80;
   localparam logic [BYTE_W-1:0] ST_NOTE_ON   = 8'h90;
   localparam logic [BYTE_W-1:0] ST_POLY_AT   = 8'hA0;
   localparam logic [BYTE_W-1:0] ST_CTRL      = 8'hB0;
   localparam logic [BYTE_W-1:0] ST_PROGRAM   = 8'hC0;
   localparam logic [BYTE_W-1:0] ST_CHAN_AT   = 8'hD0;
   localparam logic [BYTE_W-1:0] ST_PITCH     = 8'hE0;
   localparam logic [BYTE_W-1:0] ST_SYSEX     = 8'hF0;
   localparam logic [BYTE_W-1:0] ST_QFRAME    = 8'hF1;
   localparam logic [BYTE_W-1:0] ST_SONG_POS  = 8'hF2;
   localparam logic [BYTE_W-1:0] ST_SONG_SEL  = 8'hF3;
   localparam logic [BYTE_W-1:0] ST_UNDEF_F4  = 8'hF4;
   localparam logic [BYTE_W-1:0] ST_UNDEF_F5  = 8'hF5;
   localparam logic [BYTE_W-1:0] ST_TUNE      = 8'hF6;
   localparam logic [BYTE_W-1:0] ST_EOX       = 8'hF7;
   localparam logic [BYTE_W-1:0] ST_CLOCK     = 8'hF8;
   localparam logic [BYTE_W-1:0] ST_UNDEF_F9  = 8'hF9;
   localparam logic [BYTE_W-1:0] ST_START     = 8'hFA;
   localparam logic [BYTE_W-1:0] ST_CONTINUE  = 8'hFB;
   localparam logic [BYTE_W-1:0] ST_STOP      = 8'hFC;
   localparam logic [BYTE_W-1:0] ST_UNDEF_FD  = 8'hFD;
   localparam logic [BYTE_W-1:0] ST_SENSE     = 8'hFE;
   localparam logic [BYTE_W-1:0] ST_RESET     = 8'hFF;
   localparam logic [BYTE_W-1:0] STATUS_BIT   = 8'h80;
   localparam logic [BYTE_W-1:0] TYPE_MASK    = 8'hF0;
   localparam logic [BYTE_W-1:0] CHAN_MASK    = 8'h0F;

   // Active sense output codes
   localparam logic [STATE_W-1:0] SENSE_CODE_OFF  = 2'd0;
   localparam logic [STATE_W-1:0] SENSE_CODE_ON   = 2'd1;
   localparam logic [STATE_W-1:0] SENSE_CODE_FAIL = 2'd2;

   // Active sense monitor state
   typedef enum logic [2:0] {
      SENSE_OFF  = 3'b001,
      SENSE_ON   = 3'b010,
      SENSE_FAIL = 3'b100
   } sense_type;

   // One result item
   typedef struct packed {
      logic                msg_valid;
      logic [BYTE_W-1:0]   msg_type;
      logic [CHAN_W-1:0]   msg_channel;
      logic [BYTE_W-1:0]   msg_data1;
      logic [BYTE_W-1:0]   msg_data2;
      logic [LEN_W-1:0]    msg_bytes;
      logic [TIME_W-1:0]   msg_time;
      logic                sysex_valid;
      logic [SIDX_W-1:0]   sysex_index;
      logic [BYTE_W-1:0]   sysex_byte;
      logic [STATE_W-1:0]  sense_state;
   } rsp_type;

   // Message type of a byte, zero for data and undefined status bytes
   function automatic logic [BYTE_W-1:0] type_of(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] ty;
      if (b < STATUS_BIT ||
          b inside {ST_UNDEF_F4, ST_UNDEF_F5, ST_UNDEF_F9, ST_UNDEF_FD}) begin
         ty = ST_NONE;
      end else if (b < ST_SYSEX) begin
         ty = b & TYPE_MASK;
      end else begin
         ty = b;
      end
      return ty;
   endfunction

   // Channel voice type test
   function automatic logic is_voice(input logic [BYTE_W-1:0] t);
      return t inside {[ST_NOTE_OFF:ST_PITCH]};
   endfunction

   // Real-time bytes that pass through a pending message
   function automatic logic is_pass_rt(input logic [BYTE_W-1:0] b);
      return b inside {ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP, ST_RESET};
   endfunction

   // Channel number 1..16 of a status byte
   function automatic logic [CHAN_W-1:0] chan_of(input logic [BYTE_W-1:0] st);
      return CHAN_W'(st & CHAN_MASK) + CHAN_W'(1);
   endfunction

endpackage

/* src/midi_byte_stream_parser_core.sv */
// MIDI byte stream parser with running status, SysEx streaming and active sense.
//
// Takes one item per clock while req_stall is low: a received byte with its
// timestamp, or a 1 ms tick. Every accepted item gives exactly one result
// item. All parsing state updates on acceptance, so a new item can be taken
// every clock; the sustained rate is one item per cycle while req_stall is
// low. The result register is backed by a one-entry skid buffer, so req_stall
// only rises after the consumer has held rsp_stall with two results waiting,
// and req_stall is a register output. Completed messages, pass-through real-time
// bytes and SysEx bytes all appear on the result; SysEx length is reported on
// the closing 0xF7. Configuration writes take effect on the next item.
`include "midi_byte_stream_parser_core_defines.svh"

module midi_byte_stream_parser_core
   import mbp_pkg::*;
#(
   parameter int SYSEX_DEPTH = SYSEX_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   input  logic [TIME_W-1:0]     req_rx_time,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_msg_valid,
   output logic [BYTE_W-1:0]     rsp_msg_type,
   output logic [CHAN_W-1:0]     rsp_msg_channel,
   output logic [BYTE_W-1:0]     rsp_msg_data1,
   output logic [BYTE_W-1:0]     rsp_msg_data2,
   output logic [LEN_W-1:0]      rsp_msg_bytes,
   output logic [TIME_W-1:0]     rsp_msg_time,
   output logic                  rsp_sysex_valid,
   output logic [SIDX_W-1:0]     rsp_sysex_index,
   output logic [BYTE_W-1:0]     rsp_sysex_byte,
   output logic [STATE_W-1:0]    rsp_sense_state,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(SYSEX_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SYSEX_DEPTH - 1);

   // Configuration registers
   logic [CHAN_W-1:0]  listen_ff;
   logic               nvo_ff;
   logic               sense_en_ff;
   logic [SENSE_W-1:0] timeout_ff;

   // Parser state
   logic [BYTE_W-1:0]  pend_status_ff, pend_status_in;
   logic [BYTE_W-1:0]  pend_data0_ff, pend_data0_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic               exp3_ff, exp3_in;
   logic [BYTE_W-1:0]  run_status_ff, run_status_in;
   logic [TIME_W-1:0]  sx_time_ff, sx_time_in;
   sense_type          sense_ff, sense_in;
   logic [SENSE_W-1:0] sense_cnt_ff, sense_cnt_in;

   // Output register and skid entry
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;

   logic    accept;
   logic    out_take;
   rsp_type res;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         listen_ff   <= LISTEN_RESET;
         nvo_ff      <= 1'b1;
         sense_en_ff <= 1'b1;
         timeout_ff  <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LISTEN_CHANNEL: listen_ff   <= csr_wdata[CHAN_W-1:0];
            CSR_NULL_VEL_OFF:   nvo_ff      <= csr_wdata[0];
            CSR_SENSE_ENABLE:   sense_en_ff <= csr_wdata[0];
            CSR_SENSE_TIMEOUT:  timeout_ff  <= csr_wdata[SENSE_W-1:0];
            default: ;
         endcase
      end
   end

   // Parse one item: next state and its result
   always_comb begin
      logic [BYTE_W-1:0]  b;
      logic [BYTE_W-1:0]  st;
      logic [BYTE_W-1:0]  ty;
      logic [BYTE_W-1:0]  pty;
      logic [SENSE_W-1:0] cnt;
      logic [LEN_W-1:0]   len;
      logic               rs_hit;
      logic               do_first;
      logic               sysex;

      b   = req_rx_byte;
      st  = ST_NONE;
      ty  = ST_NONE;
      pty = type_of(pend_status_ff);
      cnt = sense_cnt_ff;
      len = LEN_W'(pend_idx_ff) + LEN_W'(1);
      rs_hit   = 1'b0;
      do_first = 1'b0;
      sysex    = (pend_status_ff == ST_SYSEX);

      pend_status_in = pend_status_ff;
      pend_data0_in  = pend_data0_ff;
      pend_idx_in    = pend_idx_ff;
      exp3_in        = exp3_ff;
      run_status_in  = run_status_ff;
      sx_time_in     = sx_time_ff;
      sense_in       = sense_ff;
      sense_cnt_in   = sense_cnt_ff;
      res            = '0;

      if (req_kind == KIND_TICK) begin
         // Advance the active sense timeout
         if (sense_en_ff && sense_ff == SENSE_ON) begin
            if (sense_cnt_ff != SENSE_MAX) begin
               cnt = sense_cnt_ff + SENSE_W'(1);
            end
            sense_cnt_in = cnt;
            if (cnt > timeout_ff) begin
               sense_in = SENSE_FAIL;
            end
         end
      end else if (listen_ff < LISTEN_DISABLED) begin
         sense_cnt_in = '0;

         if (pend_idx_ff == '0) begin
            do_first = 1'b1;
         end else if (b >= STATUS_BIT) begin
            // Status byte inside a message
            if (b == ST_SENSE) begin
               sense_in      = SENSE_ON;
               res.msg_valid = 1'b1;
               res.msg_type  = b;
               res.msg_bytes = LEN_W'(1);
               res.msg_time  = req_rx_time;
            end else if (is_pass_rt(b)) begin
               res.msg_valid = 1'b1;
               res.msg_type  = b;
               res.msg_bytes = LEN_W'(1);
               res.msg_time  = req_rx_time;
            end else if (b == ST_EOX && sysex) begin
               // Close the SysEx and report its length
               res.sysex_valid = 1'b1;
               res.sysex_index = SIDX_W'(pend_idx_ff);
               res.sysex_byte  = ST_EOX;
               res.msg_valid   = 1'b1;
               res.msg_type    = ST_SYSEX;
               res.msg_data1   = len[BYTE_W-1:0];
               res.msg_data2   = BYTE_W'(len[LEN_W-1:BYTE_W]);
               res.msg_bytes   = len;
               res.msg_time    = sx_time_ff;
               pend_idx_in     = '0;
               run_status_in   = ST_NONE;
            end else begin
               // Abandon the pending message and restart
               do_first = 1'b1;
            end
         end else if (sysex) begin
            // Stream a SysEx data byte, drop the message on overflow
            res.sysex_valid = 1'b1;
            res.sysex_index = SIDX_W'(pend_idx_ff);
            res.sysex_byte  = b;
            if (pend_idx_ff == IDX_LAST) begin
               pend_idx_in   = '0;
               run_status_in = ST_NONE;
            end else begin
               pend_idx_in = pend_idx_ff + IDX_W'(1);
            end
         end else if (exp3_ff && pend_idx_ff == IDX_W'(1)) begin
            // Hold the first of two data bytes
            pend_data0_in = b;
            pend_idx_in   = IDX_W'(2);
         end else begin
            // Complete a two- or three-byte message
            res.msg_valid = 1'b1;
            res.msg_type  = pty;
            res.msg_data1 = exp3_ff ? pend_data0_ff : b;
            res.msg_data2 = exp3_ff ? b : '0;
            res.msg_bytes = exp3_ff ? LEN_W'(3) : LEN_W'(2);
            res.msg_time  = req_rx_time;
            if (is_voice(pty)) begin
               res.msg_channel = chan_of(pend_status_ff);
               run_status_in   = pend_status_ff;
            end else begin
               run_status_in = ST_NONE;
            end
            if (!exp3_ff) begin
               pend_data0_in = b;
            end
            pend_idx_in = '0;
         end

         if (do_first) begin
            // First byte of a message, with running status for data bytes
            rs_hit = (b < STATUS_BIT) && is_voice(type_of(run_status_ff));
            st     = rs_hit ? run_status_ff : b;
            ty     = type_of(st);
            pend_status_in = st;
            pend_idx_in    = '0;
            if (rs_hit) begin
               pend_data0_in = b;
            end
            case (ty) inside
               ST_SENSE: begin
                  sense_in      = SENSE_ON;
                  res.msg_valid = 1'b1;
                  res.msg_type  = ty;
                  res.msg_bytes = LEN_W'(1);
                  res.msg_time  = req_rx_time;
               end
               ST_TUNE, ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP, ST_RESET: begin
                  res.msg_valid = 1'b1;
                  res.msg_type  = ty;
                  res.msg_bytes = LEN_W'(1);
                  res.msg_time  = req_rx_time;
               end
               ST_PROGRAM, ST_CHAN_AT, ST_QFRAME, ST_SONG_SEL: begin
                  exp3_in = 1'b0;
                  if (rs_hit) begin
                     res.msg_valid   = 1'b1;
                     res.msg_type    = ty;
                     res.msg_channel = chan_of(st);
                     res.msg_data1   = b;
                     res.msg_bytes   = LEN_W'(2);
                     res.msg_time    = req_rx_time;
                  end else begin
                     pend_idx_in = IDX_W'(1);
                  end
               end
               ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL, ST_PITCH,
               ST_SONG_POS: begin
                  exp3_in     = 1'b1;
                  pend_idx_in = rs_hit ? IDX_W'(2) : IDX_W'(1);
               end
               ST_SYSEX: begin
                  run_status_in   = ST_NONE;
                  sx_time_in      = req_rx_time;
                  res.sysex_valid = 1'b1;
                  res.sysex_index = '0;
                  res.sysex_byte  = ST_SYSEX;
                  pend_idx_in     = IDX_W'(1);
               end
               default: begin
                  // Stray byte: drop the message and the running status
                  run_status_in = ST_NONE;
               end
            endcase
         end

         // Apply note-off mapping and the channel filter
         if (res.msg_valid) begin
            if (nvo_ff && res.msg_type == ST_NOTE_ON && res.msg_data2 == '0) begin
               res.msg_type = ST_NOTE_OFF;
            end
            if (res.msg_type == ST_NONE) begin
               res.msg_valid = 1'b0;
            end else if (is_voice(res.msg_type) && listen_ff != LISTEN_OMNI &&
                         res.msg_channel != listen_ff) begin
               res.msg_valid = 1'b0;
            end
         end
         if (!res.msg_valid) begin
            res.msg_type    = '0;
            res.msg_channel = '0;
            res.msg_data1   = '0;
            res.msg_data2   = '0;
            res.msg_bytes   = '0;
            res.msg_time    = '0;
         end
      end

      // Report the sense state after this item
      case (sense_in)
         SENSE_OFF:  res.sense_state = SENSE_CODE_OFF;
         SENSE_ON:   res.sense_state = SENSE_CODE_ON;
         SENSE_FAIL: res.sense_state = SENSE_CODE_FAIL;
         default:    res.sense_state = SENSE_CODE_OFF;
      endcase
   end

   // Advance parser state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_status_ff <= ST_NONE;
         pend_idx_ff    <= '0;
         exp3_ff        <= 1'b0;
         run_status_ff  <= ST_NONE;
         sense_ff       <= SENSE_OFF;
         sense_cnt_ff   <= '0;
      end else if (accept) begin
         pend_status_ff <= pend_status_in;
         pend_idx_ff    <= pend_idx_in;
         exp3_ff        <= exp3_in;
         run_status_ff  <= run_status_in;
         sense_ff       <= sense_in;
         sense_cnt_ff   <= sense_cnt_in;
      end
   end

   // Hold data payload without reset
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_data0_ff <= pend_data0_in;
         sx_time_ff    <= sx_time_in;
      end
   end

   // Output register and skid entry control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Output register and skid entry payload
   always_ff @(posedge clock) begin
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (accept) begin
            out_data_ff <= res;
         end
      end else if (accept) begin
         skid_data_ff <= res;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_msg_valid   = out_data_ff.msg_valid;
   assign rsp_msg_type    = out_data_ff.msg_type;
   assign rsp_msg_channel = out_data_ff.msg_channel;
   assign rsp_msg_data1   = out_data_ff.msg_data1;
   assign rsp_msg_data2   = out_data_ff.msg_data2;
   assign rsp_msg_bytes   = out_data_ff.msg_bytes;
   assign rsp_msg_time    = out_data_ff.msg_time;
   assign rsp_sysex_valid = out_data_ff.sysex_valid;
   assign rsp_sysex_index = out_data_ff.sysex_index;
   assign rsp_sysex_byte  = out_data_ff.sysex_byte;
   assign rsp_sense_state = out_data_ff.sense_state;

   // Check buffering and parser invariants
   `MBP_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid full while output empty")
   `MBP_ASSERT_NEXT(a_skid_fills, accept && out_valid_ff && rsp_stall, skid_valid_ff, "item lost on stall")
   `MBP_ASSERT_NOW(a_sysex_no_running, pend_idx_ff != '0 && pend_status_ff == ST_SYSEX, run_status_ff == ST_NONE, "running status kept during SysEx")
   `MBP_ASSERT_NOW(a_voice_has_chan, rsp_valid && rsp_msg_valid && rsp_msg_type >= ST_NOTE_OFF && rsp_msg_type <= ST_PITCH, rsp_msg_channel != '0, "voice message without channel")

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the MIDI byte stream parser core.
module testbench
   import mbp_pkg::*;
();

   // Tracks the parser state, predicts one result per item and checks results in order
   class midi_scoreboard;
      // register copy
      logic [CHAN_W-1:0]  listen;
      logic               null_off;
      logic               sense_en;
      logic [SENSE_W-1:0] sense_limit;
      // parser state
      logic [BYTE_W-1:0]  pend_status;
      logic [BYTE_W-1:0]  pend_data [2];
      logic [SIDX_W-1:0]  pend_idx;
      logic [LEN_W-1:0]   want_len;
      logic [BYTE_W-1:0]  run_status;
      logic [TIME_W-1:0]  sx_start;
      logic [STATE_W-1:0] sense_mode;
      logic [SENSE_W-1:0] sense_cnt;
      // results still owed by the block
      rsp_type            expected_q[$];
      int unsigned        errors;
      int unsigned        checked;

      function new();
         listen      = LISTEN_RESET;
         null_off    = 1'b1;
         sense_en    = 1'b1;
         sense_limit = TIMEOUT_RESET;
         pend_status = ST_NONE;
         pend_data[0] = '0;
         pend_data[1] = '0;
         pend_idx    = '0;
         want_len    = '0;
         run_status  = ST_NONE;
         sx_start    = '0;
         sense_mode  = SENSE_CODE_OFF;
         sense_cnt   = '0;
         errors      = 0;
         checked     = 0;
      endfunction

      function void set_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_LISTEN_CHANNEL: listen = val[CHAN_W-1:0];
            CSR_NULL_VEL_OFF:   null_off = val[0];
            CSR_SENSE_ENABLE:   sense_en = val[0];
            CSR_SENSE_TIMEOUT:  sense_limit = val[SENSE_W-1:0];
            default: ;
         endcase
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      // Message class of a byte: zero for data and undefined status
      function logic [BYTE_W-1:0] status_class(input logic [BYTE_W-1:0] b);
         if (!b[7]) return ST_NONE;
         case (b)
            ST_UNDEF_F4, ST_UNDEF_F5, ST_UNDEF_F9, ST_UNDEF_FD: return ST_NONE;
            default: ;
         endcase
         if (b < ST_SYSEX) return {b[7:4], 4'h0};
         return b;
      endfunction

      function bit voice(input logic [BYTE_W-1:0] t);
         return (t >= ST_NOTE_OFF) && (t <= ST_PITCH);
      endfunction

      function logic [CHAN_W-1:0] chan_num(input logic [BYTE_W-1:0] st);
         return {1'b0, st[3:0]} + 5'd1;
      endfunction

      function void put_msg(inout rsp_type r, input logic [BYTE_W-1:0] ty,
                            input logic [CHAN_W-1:0] ch, input logic [BYTE_W-1:0] d1,
                            input logic [BYTE_W-1:0] d2, input logic [LEN_W-1:0] nbytes,
                            input logic [TIME_W-1:0] t);
         r.msg_valid   = 1'b1;
         r.msg_type    = ty;
         r.msg_channel = ch;
         r.msg_data1   = d1;
         r.msg_data2   = d2;
         r.msg_bytes   = nbytes;
         r.msg_time    = t;
      endfunction

      function void drop_input();
         pend_idx   = '0;
         want_len   = '0;
         run_status = ST_NONE;
      endfunction

      // First byte of a message, with running status for bare data bytes
      function void start_msg(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] t,
                              inout rsp_type r);
         logic [BYTE_W-1:0] st;
         logic [BYTE_W-1:0] ty;
         st = b;
         if (voice(status_class(run_status)) && !b[7]) begin
            st = run_status;
            pend_data[0] = b;
            pend_idx = 10'd1;
         end
         pend_status = st;
         ty = status_class(st);
         case (ty)
            ST_SENSE: begin
               sense_mode = SENSE_CODE_ON;
               put_msg(r, ty, '0, '0, '0, 11'd1, t);
               pend_idx = '0;
               want_len = '0;
               return;
            end
            ST_TUNE, ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP, ST_RESET: begin
               put_msg(r, ty, '0, '0, '0, 11'd1, t);
               pend_idx = '0;
               want_len = '0;
               return;
            end
            ST_PROGRAM, ST_CHAN_AT, ST_QFRAME, ST_SONG_SEL: want_len = 11'd2;
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL, ST_PITCH, ST_SONG_POS:
               want_len = 11'd3;
            ST_SYSEX: begin
               want_len = LEN_W'(SYSEX_DEPTH_DEF);
               run_status = ST_NONE;
               sx_start = t;
               r.sysex_valid = 1'b1;
               r.sysex_index = '0;
               r.sysex_byte = ST_SYSEX;
            end
            default: begin
               drop_input();
               return;
            end
         endcase
         if (pend_idx + 1'b1 >= want_len) begin
            put_msg(r, ty, chan_num(st), pend_data[0], '0, 11'd2, t);
            pend_idx = '0;
            want_len = '0;
         end else begin
            pend_idx = pend_idx + 1'b1;
         end
      endfunction

      // Byte inside a message: real-time pass-through, SysEx data or message data
      function void continue_msg(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] t,
                                 inout rsp_type r);
         bit                in_sx;
         logic [LEN_W-1:0]  len;
         logic [BYTE_W-1:0] ty;
         in_sx = (pend_status == ST_SYSEX);
         if (b[7]) begin
            case (b)
               ST_SENSE: begin
                  sense_mode = SENSE_CODE_ON;
                  put_msg(r, b, '0, '0, '0, 11'd1, t);
                  return;
               end
               ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP, ST_RESET: begin
                  put_msg(r, b, '0, '0, '0, 11'd1, t);
                  return;
               end
               ST_EOX: begin
                  if (in_sx) begin
                     len = pend_idx + 1'b1;
                     r.sysex_valid = 1'b1;
                     r.sysex_index = pend_idx;
                     r.sysex_byte = ST_EOX;
                     put_msg(r, ST_SYSEX, '0, len[7:0], {5'b0, len[10:8]}, len, sx_start);
                     drop_input();
                     return;
                  end
               end
               default: ;
            endcase
            // any other status abandons the pending message
            pend_idx = '0;
            want_len = '0;
            start_msg(b, t, r);
            return;
         end

         if (in_sx) begin
            r.sysex_valid = 1'b1;
            r.sysex_index = pend_idx;
            r.sysex_byte = b;
            if (pend_idx + 1'b1 >= want_len) drop_input();
            else pend_idx = pend_idx + 1'b1;
            return;
         end

         pend_data[~pend_idx[0]] = b;
         if (pend_idx + 1'b1 >= want_len) begin
            ty = status_class(pend_status);
            if (want_len == 11'd3)
               put_msg(r, ty, '0, pend_data[0], pend_data[1], 11'd3, t);
            else put_msg(r, ty, '0, pend_data[0], '0, 11'd2, t);
            if (voice(ty)) begin
               r.msg_channel = chan_num(pend_status);
               run_status = pend_status;
            end else begin
               run_status = ST_NONE;
            end
            pend_idx = '0;
            want_len = '0;
         end else begin
            pend_idx = pend_idx + 1'b1;
         end
      endfunction

      // Advance the state for one accepted item and queue its result
      function void note_item(input logic kind, input logic [BYTE_W-1:0] b,
                              input logic [TIME_W-1:0] t);
         rsp_type r;
         r = '0;
         if (kind == KIND_TICK) begin
            if (sense_en && sense_mode == SENSE_CODE_ON) begin
               if (sense_cnt != SENSE_MAX) sense_cnt = sense_cnt + 1'b1;
               if (sense_cnt > sense_limit) sense_mode = SENSE_CODE_FAIL;
            end
         end else if (listen < LISTEN_DISABLED) begin
            sense_cnt = '0;
            if (pend_idx == '0) start_msg(b, t, r);
            else continue_msg(b, t, r);
            if (r.msg_valid) begin
               if (null_off && r.msg_type == ST_NOTE_ON && r.msg_data2 == '0)
                  r.msg_type = ST_NOTE_OFF;
               if (r.msg_type == ST_NONE) r.msg_valid = 1'b0;
               else if (voice(r.msg_type) && listen != LISTEN_OMNI &&
                        r.msg_channel != listen)
                  r.msg_valid = 1'b0;
            end
         end
         if (!r.msg_valid) begin
            r.msg_type    = '0;
            r.msg_channel = '0;
            r.msg_data1   = '0;
            r.msg_data2   = '0;
            r.msg_bytes   = '0;
            r.msg_time    = '0;
         end
         r.sense_state = sense_mode;
         expected_q.push_back(r);
      endfunction

      task report(input string what);
         errors++;
         if (errors <= 100) $display("ERROR: result %0d: %s", checked, what);
      endtask

      task cmp(input string name, input logic [31:0] got, input logic [31:0] want);
         if (got !== want) report($sformatf("%s is %0h, predicted %0h", name, got, want));
      endtask

      // Compare one result with the oldest prediction
      task check_result(input rsp_type got);
         rsp_type want;
         checked++;
         if (expected_q.size() == 0) begin
            report("result with no item outstanding");
            return;
         end
         want = expected_q.pop_front();
         cmp("msg_valid", got.msg_valid, want.msg_valid);
         cmp("msg_type", got.msg_type, want.msg_type);
         cmp("msg_channel", got.msg_channel, want.msg_channel);
         cmp("msg_data1", got.msg_data1, want.msg_data1);
         cmp("msg_data2", got.msg_data2, want.msg_data2);
         cmp("msg_bytes", got.msg_bytes, want.msg_bytes);
         cmp("msg_time", got.msg_time, want.msg_time);
         cmp("sysex_valid", got.sysex_valid, want.sysex_valid);
         cmp("sysex_index", got.sysex_index, want.sysex_index);
         cmp("sysex_byte", got.sysex_byte, want.sysex_byte);
         cmp("sense_state", got.sense_state, want.sense_state);
      endtask
   endclass

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 100;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_kind = KIND_BYTE;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic [TIME_W-1:0]     req_rx_time = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_msg_valid;
   logic [BYTE_W-1:0]     rsp_msg_type;
   logic [CHAN_W-1:0]     rsp_msg_channel;
   logic [BYTE_W-1:0]     rsp_msg_data1;
   logic [BYTE_W-1:0]     rsp_msg_data2;
   logic [LEN_W-1:0]      rsp_msg_bytes;
   logic [TIME_W-1:0]     rsp_msg_time;
   logic                  rsp_sysex_valid;
   logic [SIDX_W-1:0]     rsp_sysex_index;
   logic [BYTE_W-1:0]     rsp_sysex_byte;
   logic [STATE_W-1:0]    rsp_sense_state;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   midi_scoreboard sb;
   int          send_idle = 0;
   int          recv_idle = 0;
   int          tick_span = 6;
   logic [3:0]  favored_ch = 4'd0;
   int unsigned holds_asked = 0;
   int unsigned holds_done = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;

   midi_byte_stream_parser_core #(
      .SYSEX_DEPTH(SYSEX_DEPTH_DEF)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_rx_byte(req_rx_byte),
      .req_rx_time(req_rx_time),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_msg_valid(rsp_msg_valid),
      .rsp_msg_type(rsp_msg_type),
      .rsp_msg_channel(rsp_msg_channel),
      .rsp_msg_data1(rsp_msg_data1),
      .rsp_msg_data2(rsp_msg_data2),
      .rsp_msg_bytes(rsp_msg_bytes),
      .rsp_msg_time(rsp_msg_time),
      .rsp_sysex_valid(rsp_sysex_valid),
      .rsp_sysex_index(rsp_sysex_index),
      .rsp_sysex_byte(rsp_sysex_byte),
      .rsp_sense_state(rsp_sense_state),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("midi_byte_stream_parser_core: mismatch");
         $finish;
      end
   end

   // Predict on each accepted item, check each accepted result
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_item(req_kind, req_rx_byte, req_rx_time);
         if (rsp_valid && !rsp_stall)
            sb.check_result({rsp_msg_valid, rsp_msg_type, rsp_msg_channel, rsp_msg_data1,
                             rsp_msg_data2, rsp_msg_bytes, rsp_msg_time, rsp_sysex_valid,
                             rsp_sysex_index, rsp_sysex_byte, rsp_sense_state});
      end
   end

   // Result side: random stalls, or a long hold when one is requested
   always @(negedge clock) begin
      if (holds_done != holds_asked) begin
         holds_done = holds_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle);
      end
   end

   // Offer one item, idling first at random, and wait until it is taken
   task automatic send_item(input logic kind, input logic [BYTE_W-1:0] b,
                            input logic [TIME_W-1:0] t);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_rx_byte <= b;
      req_rx_time <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      send_item(KIND_BYTE, b, $urandom());
   endtask

   task automatic send_tick();
      send_item(KIND_TICK, BYTE_W'($urandom_range(0, 255)), $urandom());
   endtask

   // Drop valid and hold off until every result has come back
   task automatic idle_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, CSR_DATA_W'(val));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic maybe_realtime();
      if ($urandom_range(0, 99) < 10) begin
         case ($urandom_range(0, 5))
            0: send_byte(ST_CLOCK);
            1: send_byte(ST_START);
            2: send_byte(ST_CONTINUE);
            3: send_byte(ST_STOP);
            4: send_byte(ST_RESET);
            default: send_byte(ST_SENSE);
         endcase
      end
   endtask

   function automatic logic [BYTE_W-1:0] data_value();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'h7F;
         default: return BYTE_W'($urandom_range(0, 127));
      endcase
   endfunction

   // One random phrase: mostly well-formed messages, some noise
   task automatic send_phrase();
      int                pick;
      int                ndata;
      int                i;
      logic [3:0]        ch;
      logic [BYTE_W-1:0] st;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         ch = $urandom_range(0, 1) ? favored_ch : 4'($urandom_range(0, 15));
         st = {4'($urandom_range(8, 14)), ch};
         ndata = ({st[7:4], 4'h0} == ST_PROGRAM || {st[7:4], 4'h0} == ST_CHAN_AT) ? 1 : 2;
         // leave the status out now and then to use running status
         if ($urandom_range(0, 99) < 75) send_byte(st);
         for (i = 0; i < ndata; i++) begin
            maybe_realtime();
            if (i == 1 && $urandom_range(0, 4) == 0) send_byte(8'h00);
            else send_byte(data_value());
         end
      end else if (pick < 55) begin
         case ($urandom_range(0, 3))
            0: begin
               send_byte(ST_QFRAME);
               send_byte(data_value());
            end
            1: begin
               send_byte(ST_SONG_POS);
               maybe_realtime();
               send_byte(data_value());
               send_byte(data_value());
            end
            2: begin
               send_byte(ST_SONG_SEL);
               send_byte(data_value());
            end
            default: send_byte(ST_TUNE);
         endcase
      end else if (pick < 65) begin
         // SysEx, rarely long enough to overflow the buffer
         ndata = ($urandom_range(0, 14) == 0) ? $urandom_range(120, 135) : $urandom_range(0, 8);
         send_byte(ST_SYSEX);
         for (i = 0; i < ndata; i++) begin
            maybe_realtime();
            send_byte(data_value());
         end
         if ($urandom_range(0, 99) < 80) send_byte(ST_EOX);
         else send_byte(BYTE_W'($urandom_range(128, 255)));
      end else if (pick < 75) begin
         maybe_realtime();
         send_byte(($urandom_range(0, 2) == 0) ? ST_SENSE : ST_CLOCK);
      end else if (pick < 85) begin
         ndata = $urandom_range(1, tick_span);
         for (i = 0; i < ndata; i++) send_tick();
      end else begin
         send_item(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)), $urandom());
      end
   endtask

   task automatic run_random(input int count);
      int unsigned start;
      start = sb.checked + sb.outstanding();
      while (sb.checked + sb.outstanding() < start + count) send_phrase();
   endtask

   // Field extremes, most message types and special cases such as running status
   task automatic run_directed();
      send_item(KIND_BYTE, ST_SENSE, 32'h0000_0000);
      send_tick();
      send_byte(8'h9F);
      send_byte(8'h7F);
      send_byte(8'h00);
      send_byte(8'h3C);
      send_byte(8'h40);
      send_byte(8'hC5);
      send_byte(8'h12);
      send_byte(8'h55);
      send_byte(ST_PITCH);
      send_byte(8'h00);
      send_item(KIND_BYTE, 8'h7F, 32'hFFFF_FFFF);
      send_byte(8'hB3);
      send_byte(8'h07);
      send_byte(ST_CLOCK);
      send_byte(8'h64);
      send_byte(ST_SYSEX);
      send_byte(8'h01);
      send_byte(ST_EOX);
      send_byte(ST_EOX);
      send_byte(ST_UNDEF_F4);
      send_byte(8'h20);
      send_byte(ST_SONG_POS);
      send_byte(8'h10);
      send_byte(8'hA1);
      send_byte(ST_QFRAME);
      send_byte(8'h33);
      send_byte(ST_TUNE);
      send_byte(ST_RESET);
      send_byte(8'hD2);
      send_byte(8'h7F);
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver stalls often; reset register values
      send_idle = 22;
      recv_idle = 72;
      run_directed();
      run_random(150);
      idle_until_drained();

      // roles swapped; last channel only, timeout of 1
      write_reg(CSR_LISTEN_CHANNEL, 16);
      write_reg(CSR_NULL_VEL_OFF, 0);
      write_reg(CSR_SENSE_ENABLE, 1);
      write_reg(CSR_SENSE_TIMEOUT, 1);
      favored_ch = 4'd15;
      send_idle = 72;
      recv_idle = 22;
      run_random(80);
      // long receiver hold while items keep coming, to fill the block
      send_idle = 0;
      holds_asked++;
      run_random(40);
      send_idle = 72;
      idle_until_drained();
      run_random(60);
      idle_until_drained();

      // no idling from here; first channel, sense frozen, longest timeout
      write_reg(CSR_LISTEN_CHANNEL, 1);
      write_reg(CSR_NULL_VEL_OFF, 1);
      write_reg(CSR_SENSE_ENABLE, 0);
      write_reg(CSR_SENSE_TIMEOUT, 1023);
      favored_ch = 4'd0;
      send_idle = 0;
      recv_idle = 0;
      run_random(100);
      idle_until_drained();

      // input disabled: bytes dropped, ticks still act
      write_reg(CSR_LISTEN_CHANNEL, LISTEN_DISABLED);
      write_reg(CSR_SENSE_ENABLE, 1);
      write_reg(CSR_SENSE_TIMEOUT, 3);
      run_random(40);
      idle_until_drained();

      // omni with a random timeout and longer tick bursts
      write_reg(CSR_LISTEN_CHANNEL, LISTEN_OMNI);
      write_reg(CSR_NULL_VEL_OFF, 0);
      write_reg(CSR_SENSE_TIMEOUT, $urandom_range(2, 40));
      favored_ch = 4'($urandom_range(0, 15));
      tick_span = 45;
      run_random(150);
      idle_until_drained();

      // let any stray late result show up
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("midi_byte_stream_parser_core: match");
      end else begin
         $display("midi_byte_stream_parser_core: mismatch");
      end
      $finish;
   end
endmodule
